// ===== design/slrs_pkg.sv =====
// ----------------------------------------------------------------------------
// slrs_pkg
// Shared types and constants of the lattice reaction step core.
// ----------------------------------------------------------------------------
package slrs_pkg;

  localparam int CELL_SLOTS = 64;
  localparam int CELL_AW    = 6;
  localparam int PROP_DEPTH = 256;
  localparam int PROP_AW    = 8;
  localparam int PROP_W     = 32;
  localparam int TIME_W     = 24;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  // Serial divider geometry: 56-bit dividend, 32-bit divisor.
  localparam int DIV_W  = 56;
  localparam int DIVR_W = 32;

  localparam logic [15:0] LN2_Q16   = 16'd45426;
  localparam logic [6:0]  HILL_K    = 7'd100;
  localparam logic [TIME_W-1:0] END_TIME_RST = 24'hA0000;
  localparam logic [TIME_W-1:0] TIME_MAX     = 24'hFFFFFF;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_STEP  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [1:0] ST_FIRED = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_END   = 2'd2;
  localparam logic [1:0] ST_ACK   = 2'd3;

  localparam logic [1:0] KIND_NOTCH_UP = 2'd0;
  localparam logic [1:0] KIND_NOTCH_DN = 2'd1;
  localparam logic [1:0] KIND_DELTA_UP = 2'd2;
  localparam logic [1:0] KIND_DELTA_DN = 2'd3;

  localparam logic REG_END_TIME = 1'b0;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  cell_addr;
    logic [7:0]  notch_count;
    logic [7:0]  delta_count;
    logic [7:0]  ceiling_count;
    logic [15:0] random_a;
    logic [15:0] random_b;
  } item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [5:0]        chosen_cell;
    logic [1:0]        reaction_kind;
    logic [7:0]        new_notch;
    logic [7:0]        new_delta;
    logic [7:0]        read_ceiling;
    logic [TIME_W-1:0] step_time;
    logic [TIME_W-1:0] elapsed_time;
    logic              run_done;
  } result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Hexagonal neighbour offsets, in the order the delta sum visits them.
  function automatic int nb_dx(input logic [2:0] k);
    int r;
    case (k)
      3'd0: r = -1;
      3'd1: r = 0;
      3'd2: r = -1;
      3'd3: r = 1;
      3'd4: r = 0;
      3'd5: r = 1;
      default: r = 0;
    endcase
    return r;
  endfunction

  function automatic int nb_dy(input logic [2:0] k);
    int r;
    case (k)
      3'd0: r = -1;
      3'd1: r = -1;
      3'd2: r = 0;
      3'd3: r = 0;
      3'd4: r = 1;
      3'd5: r = 1;
      default: r = 0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/stochastic_lattice_reaction_step_core.sv =====
// ----------------------------------------------------------------------------
// stochastic_lattice_reaction_step_core
// One Gillespie direct-method step over a hexagonal grid of notch/delta cells.
// ----------------------------------------------------------------------------
// Load and clear commands pass through S_CMD to S_FINISH, read commands through
// S_CMD, S_RDDONE and S_FINISH. A step runs a small sequencer around one 32x32
// multiplier and one bit-serial divider: each cell takes seven cell RAM reads,
// seven multiplies, up to two divisions and four propensity writes; then come
// the logarithm, the step time division and the selection walk, which reads the
// propensity entries one at a time. The divider sets most of the run time of a
// step. Input is stalled while a command is in work, and one finished result
// can wait in the output register.
module stochastic_lattice_reaction_step_core #(
  parameter int GRID_X = 8,
  parameter int GRID_Y = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  slrs_pkg::item_t                item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output slrs_pkg::result_t              result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [slrs_pkg::PADDR_W-1:0]   paddr,
  input  logic [slrs_pkg::PDATA_W-1:0]   pwdata,
  output logic [slrs_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import slrs_pkg::*;

  localparam int NCELLS = (GRID_X * GRID_Y > CELL_SLOTS) ? CELL_SLOTS : GRID_X * GRID_Y;
  localparam int XW = $clog2(GRID_X + 1);
  localparam int YW = $clog2(GRID_Y + 1);
  localparam logic [CELL_AW-1:0] LAST_CELL = CELL_AW'(NCELLS - 1);
  localparam logic [PROP_AW-1:0] LAST_ENT  = PROP_AW'(4 * NCELLS - 1);

  typedef enum logic [5:0] {
    S_IDLE, S_CMD, S_RDDONE, S_CHECK, S_CELL_RD, S_CELL_LAT, S_NB,
    S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8,
    S_DIVN_GO, S_DIVN_W, S_WR1, S_DIVD_GO, S_DIVD_W, S_WR3,
    S_TOTAL, S_LSQ, S_LNORM, S_LN, S_LN2, S_TAU, S_TGT, S_TGT2,
    S_SEL_RD, S_SEL_CHK, S_APPLY_RD, S_APPLY, S_FINISH
  } state_t;

  state_t state;

  logic [TIME_W-1:0] end_time;
  logic [TIME_W-1:0] time_now;
  item_t             item_q;
  result_t           res;

  // Fill-pass registers.
  logic [CELL_AW-1:0] c;
  logic [XW-1:0]      x;
  logic [YW-1:0]      y;
  logic [2:0]         k;
  logic               nb_ok;
  logic [7:0]         n;
  logic [7:0]         d;
  logic [7:0]         z;
  logic [10:0]        s;
  logic [27:0]        hs;
  logic [15:0]        zz;
  logic [35:0]        num_n;
  logic [23:0]        z3;
  logic [22:0]        hn;
  logic [31:0]        total;

  // Logarithm, time and selection registers.
  logic [4:0]         lk;
  logic [31:0]        m;
  logic [15:0]        frac;
  logic [3:0]         li;
  logic [TIME_W-1:0]  tau;
  logic [47:0]        target;
  logic [32:0]        cum;
  logic [PROP_AW-1:0] j;
  logic [PROP_AW-1:0] pick;

  // Shared multiplier with a registered product.
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] p;

  // Cell stores.
  logic [CELL_AW-1:0] cell_raddr;
  logic [CELL_AW-1:0] cell_waddr;
  logic               notch_we;
  logic               delta_we;
  logic               ceil_we;
  logic [7:0]         notch_wdata;
  logic [7:0]         delta_wdata;
  logic [7:0]         notch_rdata;
  logic [7:0]         delta_rdata;
  logic [7:0]         ceil_rdata;

  // Propensity store.
  logic               prop_we;
  logic [PROP_AW-1:0] prop_waddr;
  logic [PROP_W-1:0]  prop_wdata;
  logic [PROP_W-1:0]  prop_rdata;

  // Divider.
  logic              div_start;
  logic [DIV_W-1:0]  div_dividend;
  logic [DIVR_W-1:0] div_divisor;
  div_stat_t         div_stat;
  logic [DIV_W-1:0]  div_q;

  // Neighbour address and existence.
  int                 nx;
  int                 ny;
  int                 ni;
  logic               nb_exists;
  logic [CELL_AW-1:0] nb_addr;

  logic               cell_exists;
  logic [16:0]        a1;
  logic [4:0]         msb_pos;
  logic [32:0]        cum_sum;
  logic [24:0]        time_sum;
  logic [7:0]         apply_n;
  logic [7:0]         apply_d;
  logic [1:0]         kind;

  always_comb begin
    nx = int'(x) + nb_dx(k);
    ny = int'(y) + nb_dy(k);
    ni = nx * GRID_Y + ny;
    nb_exists = (k < 3'd6) && (nx >= 0) && (nx < GRID_X) && (ny >= 0) && (ny < GRID_Y)
                && (ni < NCELLS);
    nb_addr = CELL_AW'(ni);
  end

  assign cell_exists = 7'(item_q.cell_addr) < 7'(NCELLS);
  assign a1 = 17'(item_q.random_a) + 17'd1;

  always_comb begin
    msb_pos = '0;
    for (int b = 0; b < 17; b++) begin
      if (a1[b]) begin
        msb_pos = 5'(b);
      end
    end
  end

  assign cum_sum  = cum + 33'(prop_rdata);
  assign time_sum = 25'(time_now) + 25'(tau);
  assign kind     = pick[1:0];

  always_comb begin
    apply_n = notch_rdata;
    apply_d = delta_rdata;
    case (kind)
      KIND_NOTCH_UP: apply_n = notch_rdata + 8'd1;
      KIND_NOTCH_DN: apply_n = notch_rdata - 8'd1;
      KIND_DELTA_UP: apply_d = delta_rdata + 8'd1;
      default:       apply_d = delta_rdata - 8'd1;
    endcase
  end

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_M1:    begin mul_a = 32'(s);       mul_b = 32'(s);      end
      S_M2:    begin mul_a = p[31:0];      mul_b = 32'(HILL_K); end
      S_M3:    begin mul_a = 32'(z);       mul_b = 32'(z);      end
      S_M4:    begin mul_a = 32'(hs);      mul_b = 32'(z);      end
      S_M5:    begin mul_a = 32'(zz);      mul_b = 32'(z);      end
      S_M6:    begin mul_a = 32'(n);       mul_b = 32'(n);      end
      S_M7:    begin mul_a = p[31:0];      mul_b = 32'(HILL_K); end
      S_LSQ:   begin mul_a = m;            mul_b = m;           end
      S_LN:    begin
        mul_a = 32'(21'h100000 - {lk, frac});
        mul_b = 32'(LN2_Q16);
      end
      S_TGT:   begin mul_a = 32'(item_q.random_b); mul_b = total; end
      default: begin mul_a = '0;           mul_b = '0;          end
    endcase
  end

  always_ff @(posedge clk) begin
    p <= mul_a * mul_b;
  end

  // Cell store ports.
  always_comb begin
    unique case (state)
      S_CMD:      cell_raddr = item_q.cell_addr;
      S_NB:       cell_raddr = nb_addr;
      S_APPLY_RD: cell_raddr = pick[PROP_AW-1:2];
      default:    cell_raddr = c;
    endcase
    cell_waddr  = (state == S_APPLY) ? pick[PROP_AW-1:2] : item_q.cell_addr;
    notch_wdata = (state == S_APPLY) ? apply_n : item_q.notch_count;
    delta_wdata = (state == S_APPLY) ? apply_d : item_q.delta_count;
    ceil_we  = (state == S_CMD) && (item_q.cmd == CMD_LOAD) && cell_exists;
    notch_we = ceil_we || ((state == S_APPLY) && !kind[1]);
    delta_we = ceil_we || ((state == S_APPLY) && kind[1]);
  end

  // Propensity writes during the fill pass.
  always_comb begin
    prop_we    = 1'b0;
    prop_waddr = {c, 2'd0};
    prop_wdata = '0;
    unique case (state)
      S_DIVN_GO: begin
        prop_we    = !(n < z);
        prop_waddr = {c, KIND_NOTCH_UP};
      end
      S_DIVN_W: begin
        prop_we    = div_stat.done;
        prop_waddr = {c, KIND_NOTCH_UP};
        prop_wdata = div_q[PROP_W-1:0];
      end
      S_WR1: begin
        prop_we    = 1'b1;
        prop_waddr = {c, KIND_NOTCH_DN};
        prop_wdata = {8'd0, n, 16'd0};
      end
      S_DIVD_GO: begin
        prop_we    = !(d < z);
        prop_waddr = {c, KIND_DELTA_UP};
      end
      S_DIVD_W: begin
        prop_we    = div_stat.done;
        prop_waddr = {c, KIND_DELTA_UP};
        prop_wdata = div_q[PROP_W-1:0];
      end
      S_WR3: begin
        prop_we    = 1'b1;
        prop_waddr = {c, KIND_DELTA_DN};
        prop_wdata = {8'd0, d, 16'd0};
      end
      default: begin
        prop_we = 1'b0;
      end
    endcase
  end

  // Divider operands.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    unique case (state)
      S_DIVN_GO: begin
        div_start    = n < z;
        div_dividend = DIV_W'({num_n, 16'd0});
        div_divisor  = DIVR_W'(29'(zz) + 29'(hs));
      end
      S_DIVD_GO: begin
        div_start    = d < z;
        div_dividend = DIV_W'({z3, 16'd0});
        div_divisor  = DIVR_W'(24'(zz) + 24'(hn));
      end
      S_LN2: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'({p[35:16], 16'd0});
        div_divisor  = total;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  slrs_ram #(.WIDTH(8), .DEPTH(CELL_SLOTS)) u_notch_ram (
    .clk, .we(notch_we), .waddr(cell_waddr), .wdata(notch_wdata),
    .raddr(cell_raddr), .rdata(notch_rdata)
  );

  slrs_ram #(.WIDTH(8), .DEPTH(CELL_SLOTS)) u_delta_ram (
    .clk, .we(delta_we), .waddr(cell_waddr), .wdata(delta_wdata),
    .raddr(cell_raddr), .rdata(delta_rdata)
  );

  slrs_ram #(.WIDTH(8), .DEPTH(CELL_SLOTS)) u_ceil_ram (
    .clk, .we(ceil_we), .waddr(cell_waddr), .wdata(item_q.ceiling_count),
    .raddr(cell_raddr), .rdata(ceil_rdata)
  );

  slrs_ram #(.WIDTH(PROP_W), .DEPTH(PROP_DEPTH)) u_prop_ram (
    .clk, .we(prop_we), .waddr(prop_waddr), .wdata(prop_wdata),
    .raddr(j), .rdata(prop_rdata)
  );

  slrs_div u_div (
    .clk, .rst, .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .stat(div_stat), .quotient(div_q)
  );

  assign item_stall = state != S_IDLE;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_END_TIME) ? PDATA_W'(end_time) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      end_time <= END_TIME_RST;
    end else if (psel && penable && pwrite && (paddr[2] == REG_END_TIME)) begin
      end_time <= pwdata[TIME_W-1:0];
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      time_now     <= '0;
    end else begin
      if (result_valid && !result_stall && (state != S_FINISH)) begin
        result_valid <= 1'b0;
      end
      if (prop_we) begin
        total <= total + prop_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            item_q <= item;
            state  <= (item.cmd == CMD_STEP) ? S_CHECK : S_CMD;
          end
        end
        S_CMD: begin
          res.status        <= ST_ACK;
          res.chosen_cell   <= item_q.cell_addr;
          res.reaction_kind <= '0;
          res.step_time     <= '0;
          if (item_q.cmd == CMD_CLEAR) begin
            time_now         <= '0;
            res.elapsed_time <= '0;
            res.run_done     <= end_time == '0;
          end else begin
            res.elapsed_time <= time_now;
            res.run_done     <= time_now >= end_time;
          end
          if ((item_q.cmd == CMD_LOAD) && cell_exists) begin
            res.new_notch    <= item_q.notch_count;
            res.new_delta    <= item_q.delta_count;
            res.read_ceiling <= item_q.ceiling_count;
          end else begin
            res.new_notch    <= '0;
            res.new_delta    <= '0;
            res.read_ceiling <= '0;
          end
          state <= (item_q.cmd == CMD_READ) ? S_RDDONE : S_FINISH;
        end
        S_RDDONE: begin
          if (cell_exists) begin
            res.new_notch    <= notch_rdata;
            res.new_delta    <= delta_rdata;
            res.read_ceiling <= ceil_rdata;
          end
          state <= S_FINISH;
        end
        S_CHECK: begin
          if (time_now >= end_time) begin
            res.status        <= ST_END;
            res.chosen_cell   <= '0;
            res.reaction_kind <= '0;
            res.new_notch     <= '0;
            res.new_delta     <= '0;
            res.read_ceiling  <= '0;
            res.step_time     <= '0;
            res.elapsed_time  <= time_now;
            res.run_done      <= 1'b1;
            state             <= S_FINISH;
          end else begin
            res   <= '0;
            c     <= '0;
            x     <= '0;
            y     <= '0;
            total <= '0;
            state <= S_CELL_RD;
          end
        end
        S_CELL_RD: begin
          state <= S_CELL_LAT;
        end
        S_CELL_LAT: begin
          n     <= notch_rdata;
          d     <= delta_rdata;
          z     <= ceil_rdata;
          s     <= '0;
          k     <= '0;
          nb_ok <= 1'b0;
          state <= S_NB;
        end
        S_NB: begin
          // Data of the neighbour addressed in the previous cycle arrives now.
          if (nb_ok) begin
            s <= s + 11'(delta_rdata);
          end
          nb_ok <= nb_exists;
          k     <= k + 3'd1;
          if (k == 3'd6) begin
            state <= S_M1;
          end
        end
        S_M1: state <= S_M2;
        S_M2: state <= S_M3;
        S_M3: begin
          hs    <= p[27:0];
          state <= S_M4;
        end
        S_M4: begin
          zz    <= p[15:0];
          state <= S_M5;
        end
        S_M5: begin
          num_n <= p[35:0];
          state <= S_M6;
        end
        S_M6: begin
          z3    <= p[23:0];
          state <= S_M7;
        end
        S_M7: state <= S_M8;
        S_M8: begin
          hn    <= p[22:0];
          state <= S_DIVN_GO;
        end
        S_DIVN_GO: begin
          state <= (n < z) ? S_DIVN_W : S_WR1;
        end
        S_DIVN_W: begin
          if (div_stat.done) begin
            state <= S_WR1;
          end
        end
        S_WR1: begin
          state <= S_DIVD_GO;
        end
        S_DIVD_GO: begin
          state <= (d < z) ? S_DIVD_W : S_WR3;
        end
        S_DIVD_W: begin
          if (div_stat.done) begin
            state <= S_WR3;
          end
        end
        S_WR3: begin
          if (c == LAST_CELL) begin
            state <= S_TOTAL;
          end else begin
            c <= c + CELL_AW'(1);
            if (y == YW'(GRID_Y - 1)) begin
              y <= '0;
              x <= x + XW'(1);
            end else begin
              y <= y + YW'(1);
            end
            state <= S_CELL_RD;
          end
        end
        S_TOTAL: begin
          if (total == '0) begin
            time_now         <= end_time;
            res.status       <= ST_NONE;
            res.elapsed_time <= end_time;
            res.run_done     <= 1'b1;
            state            <= S_FINISH;
          end else begin
            // Normalize so the leading one of random_a+1 sits at bit 30.
            lk    <= msb_pos;
            m     <= 32'(a1) << (5'd30 - msb_pos);
            frac  <= '0;
            li    <= 4'd15;
            state <= S_LSQ;
          end
        end
        S_LSQ: begin
          state <= S_LNORM;
        end
        S_LNORM: begin
          if (p[61]) begin
            m        <= {1'b0, p[61:31]};
            frac[li] <= 1'b1;
          end else begin
            m <= p[61:30];
          end
          if (li == 4'd0) begin
            state <= S_LN;
          end else begin
            li    <= li - 4'd1;
            state <= S_LSQ;
          end
        end
        S_LN:  state <= S_LN2;
        S_LN2: state <= S_TAU;
        S_TAU: begin
          if (div_stat.done) begin
            if (div_q > DIV_W'(TIME_MAX)) begin
              tau <= TIME_MAX;
            end else begin
              tau <= div_q[TIME_W-1:0];
            end
            state <= S_TGT;
          end
        end
        S_TGT: begin
          if (time_sum > 25'(end_time)) begin
            time_now <= end_time;
          end else begin
            time_now <= time_sum[TIME_W-1:0];
          end
          state <= S_TGT2;
        end
        S_TGT2: begin
          target <= p[47:0];
          cum    <= '0;
          j      <= '0;
          state  <= S_SEL_RD;
        end
        S_SEL_RD: begin
          state <= S_SEL_CHK;
        end
        S_SEL_CHK: begin
          cum <= cum_sum;
          if (({cum_sum, 16'd0} > 49'(target)) || (j == LAST_ENT)) begin
            pick  <= j;
            state <= S_APPLY_RD;
          end else begin
            j     <= j + PROP_AW'(1);
            state <= S_SEL_RD;
          end
        end
        S_APPLY_RD: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          res.status        <= ST_FIRED;
          res.chosen_cell   <= pick[PROP_AW-1:2];
          res.reaction_kind <= kind;
          res.new_notch     <= apply_n;
          res.new_delta     <= apply_d;
          res.read_ceiling  <= ceil_rdata;
          res.step_time     <= tau;
          res.elapsed_time  <= time_now;
          res.run_done      <= time_now >= end_time;
          state             <= S_FINISH;
        end
        S_FINISH: begin
          if (!result_valid || !result_stall) begin
            result       <= res;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_pick_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY) |-> (pick <= LAST_ENT))
    else $error("selected entry beyond the grid");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_FINISH))
    else $error("result transfer raised outside the finish state");

endmodule

// ===== design/slrs_ram.sv =====
// ----------------------------------------------------------------------------
// slrs_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module slrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/slrs_div.sv =====
// ----------------------------------------------------------------------------
// slrs_div
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module slrs_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [slrs_pkg::DIV_W-1:0]  dividend,
  input  logic [slrs_pkg::DIVR_W-1:0] divisor,
  output slrs_pkg::div_stat_t       stat,
  output logic [slrs_pkg::DIV_W-1:0]  quotient
);
  import slrs_pkg::*;

  logic [DIVR_W-1:0]  rem;
  logic [DIVR_W-1:0]  dsr;
  logic [DIV_W-1:0]   quo;
  logic [5:0]         cnt;
  logic               busy;
  logic               done;
  logic [DIVR_W:0]    shifted;
  logic               ge;
  logic [DIVR_W-1:0]  rem_next;

  // The remainder always stays below the divisor, so one more bit fits.
  always_comb begin
    shifted  = {rem, quo[DIV_W-1]};
    ge       = shifted >= {1'b0, dsr};
    rem_next = ge ? DIVR_W'(shifted - {1'b0, dsr}) : shifted[DIVR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        dsr  <= divisor;
        quo  <= dividend;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[DIV_W-2:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule
